@@ src/lsh_pkg.sv @@
// Shared types, constants and the mix row function for the lookup2 string hash.
package lsh_pkg;

  localparam logic [31:0] GOLDEN = 32'h9e3779b9;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Mix unit: one row per cycle
  localparam int MIX_ROWS = 9;
  localparam int ROW_W    = $clog2(MIX_ROWS);

  // Work kinds placed in the queue by the front
  localparam logic [1:0] OP_BLOCK = 2'd0;  // full block, no result
  localparam logic [1:0] OP_TAIL  = 2'd1;  // short last block, result
  localparam logic [1:0] OP_BOTH  = 2'd2;  // full last block then empty tail

  typedef struct packed {
    logic [1:0]  op;
    logic        first;
    logic [31:0] seed;
    logic [31:0] wa;
    logic [31:0] wb;
    logic [31:0] wc;      // word added into c on the first pass
    logic [31:0] tail_c;  // added into c on the second pass of OP_BOTH
  } lsh_entry_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lsh_abc_t;

  // One row of the subtract-xor-shift mix.
  function automatic lsh_abc_t mix_row(input logic [ROW_W-1:0] row, input lsh_abc_t s);
    lsh_abc_t r;
    r = s;
    unique case (row)
      4'd0:    r.a = (s.a - s.b - s.c) ^ (s.c >> 13);
      4'd1:    r.b = (s.b - s.c - s.a) ^ (s.a << 8);
      4'd2:    r.c = (s.c - s.a - s.b) ^ (s.b >> 13);
      4'd3:    r.a = (s.a - s.b - s.c) ^ (s.c >> 12);
      4'd4:    r.b = (s.b - s.c - s.a) ^ (s.a << 16);
      4'd5:    r.c = (s.c - s.a - s.b) ^ (s.b >> 5);
      4'd6:    r.a = (s.a - s.b - s.c) ^ (s.c >> 3);
      4'd7:    r.b = (s.b - s.c - s.a) ^ (s.a << 10);
      4'd8:    r.c = (s.c - s.a - s.b) ^ (s.b >> 15);
      default: r = s;
    endcase
    return r;
  endfunction

endpackage

@@ src/lsh_front.sv @@
// Front end: accepts blocks, tracks message position and length, builds queue entries.
module lsh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [31:0]       word_a,
  input  logic [31:0]       word_b,
  input  logic [31:0]       word_c,
  input  logic [3:0]        byte_count,
  input  logic              last_block,
  input  logic [31:0]       seed,
  input  logic              q_full,
  output logic              in_ready,
  output logic              push,
  output lsh_pkg::lsh_entry_t push_entry
);
  import lsh_pkg::*;

  logic        mid_r, mid_nxt;
  logic [31:0] total_r, total_nxt;
  logic [3:0]  cnt;
  logic [95:0] keep;
  logic [31:0] total_base, total_sum, wc_masked;
  logic        is_tail;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  assign cnt = (byte_count > 4'd12) ? 4'd12 : byte_count;

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      keep[i*8 +: 8] = (4'(i) < cnt) ? 8'hff : 8'h00;
    end
  end

  assign is_tail    = last_block && (cnt != 4'd12);
  assign total_base = mid_r ? total_r : 32'd0;
  assign total_sum  = total_base + (is_tail ? {28'd0, cnt} : 32'd12);
  assign wc_masked  = word_c & keep[95:64];

  always_comb begin
    push_entry.first  = !mid_r;
    push_entry.seed   = seed;
    push_entry.tail_c = total_sum;
    priority if (!last_block) begin
      push_entry.op = OP_BLOCK;
      push_entry.wa = word_a;
      push_entry.wb = word_b;
      push_entry.wc = word_c;
    end else if (!is_tail) begin
      push_entry.op = OP_BOTH;
      push_entry.wa = word_a;
      push_entry.wb = word_b;
      push_entry.wc = word_c;
    end else begin
      push_entry.op = OP_TAIL;
      push_entry.wa = word_a & keep[31:0];
      push_entry.wb = word_b & keep[63:32];
      push_entry.wc = total_sum + {wc_masked[23:0], 8'd0};
    end
  end

  always_comb begin
    mid_nxt   = mid_r;
    total_nxt = total_r;
    if (push) begin
      mid_nxt   = !last_block;
      total_nxt = total_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else begin
      mid_r <= mid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r <= total_nxt;
  end

endmodule

@@ src/lsh_queue.sv @@
// Short FIFO of work entries between the front end and the mix engine.
module lsh_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lsh_pkg::lsh_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output lsh_pkg::lsh_entry_t head
);
  import lsh_pkg::*;

  lsh_entry_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  assign full    = (cnt_r == QCNT_W'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ src/lsh_back.sv @@
// Mix engine: adds each block into a/b/c, runs the mix one row a cycle, emits the hash.
module lsh_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  lsh_pkg::lsh_entry_t q_head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         hash_value
);
  import lsh_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  lsh_abc_t         abc_r, abc_nxt, mixed;
  logic [31:0]      tail_c_r, tail_c_nxt;
  logic             tail_pend_r, tail_pend_nxt;
  logic             emit_r, emit_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      hash_r, hash_nxt;
  logic             load_out;
  logic [31:0]      base_a, base_b, base_c;

  assign mixed = mix_row(row_r, abc_r);
  assign pop   = (state_r == ST_IDLE) && !q_empty;

  assign base_a = q_head.first ? GOLDEN : abc_r.a;
  assign base_b = q_head.first ? GOLDEN : abc_r.b;
  assign base_c = q_head.first ? q_head.seed : abc_r.c;

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    abc_nxt       = abc_r;
    tail_c_nxt    = tail_c_r;
    tail_pend_nxt = tail_pend_r;
    emit_nxt      = emit_r;
    load_out      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          abc_nxt.a     = base_a + q_head.wa;
          abc_nxt.b     = base_b + q_head.wb;
          abc_nxt.c     = base_c + q_head.wc;
          tail_c_nxt    = q_head.tail_c;
          tail_pend_nxt = (q_head.op == OP_BOTH);
          emit_nxt      = (q_head.op == OP_BOTH) || (q_head.op == OP_TAIL);
          row_nxt       = '0;
          state_nxt     = ST_MIX;
        end
      end
      ST_MIX: begin
        abc_nxt = mixed;
        row_nxt = row_r + 1'b1;
        if (row_r == ROW_W'(MIX_ROWS - 1)) begin
          priority if (tail_pend_r) begin
            state_nxt = ST_TAIL;
          end else if (emit_r) begin
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_TAIL: begin
        // empty tail after a full last block: only the length goes into c
        abc_nxt.c     = abc_r.c + tail_c_r;
        tail_pend_nxt = 1'b0;
        row_nxt       = '0;
        state_nxt     = ST_MIX;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    hash_nxt      = hash_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
      hash_nxt      = abc_r.c;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid  = out_valid_r;
  assign hash_value = hash_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_r       <= '0;
      tail_pend_r <= 1'b0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      tail_pend_r <= tail_pend_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    abc_r    <= abc_nxt;
    tail_c_r <= tail_c_nxt;
    hash_r   <= hash_nxt;
  end

  a_pop_starts_mix: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (state_r == ST_MIX) && (row_r == '0))
    else $error("pop did not start a mix pass");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIX) |-> (row_r < ROW_W'(MIX_ROWS)))
    else $error("mix row out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_emit_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !out_valid_r) |=> out_valid_r && (state_r == ST_IDLE))
    else $error("pending hash not delivered to result register");

endmodule

@@ src/lookup2_string_hash.sv @@
// Top level of the lookup2 string hash: front end, work queue and mix engine.
//
// Input channel (in_*): one 12-byte block per item. in_tdata carries the three
// little-endian message words and the seed, in_tuser the valid byte count,
// in_tlast marks the final block. The seed is used only on a message's first item.
// Result channel (out_*): one 32-bit hash per message, after its last item.
//
// Processing: the mix engine loads each block, then runs the nine mix rows one a
// cycle in the shared mix unit. A short last block then passes through a result
// state; a last block holding all 12 bytes first adds the length into c and runs
// the nine rows again (full block pass plus empty tail pass), then the result state.
// A 4-entry queue decouples the front end: in_tready stays high while it has
// room, so several blocks are taken back to back while the engine is busy.
// The engine pops the next block only once it has returned to its idle state.
//
// Reset (rst_n low, synchronous) empties the queue, drops any partial message
// and any pending result. When out_tready is low the hash waits in the output
// register; the engine stalls only when a second hash is ready behind it, and
// the queue then fills until in_tready drops.
module lookup2_string_hash (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [127:0]  in_tdata,   // word_a[31:0], word_b[63:32], word_c[95:64], seed[127:96]
  input  logic [3:0]    in_tuser,   // byte_count[3:0]
  input  logic          in_tlast,   // last_block
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata   // hash_value[31:0]
);
  import lsh_pkg::*;

  logic       push, pop, q_full, q_empty;
  lsh_entry_t push_entry, q_head;

  lsh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .word_a     (in_tdata[31:0]),
    .word_b     (in_tdata[63:32]),
    .word_c     (in_tdata[95:64]),
    .byte_count (in_tuser),
    .last_block (in_tlast),
    .seed       (in_tdata[127:96]),
    .q_full     (q_full),
    .in_ready   (in_tready),
    .push       (push),
    .push_entry (push_entry)
  );

  lsh_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  lsh_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .hash_value (out_tdata)
  );

endmodule
